@@ rtl/core/cau_pkg.sv @@
// ============================================================================
// cau_pkg: shared constants for the complex arithmetic unit
// Widths, commands, CORDIC angle table and gain constant.
// ============================================================================
package cau_pkg;

  localparam int unsigned DataWidth    = 16;
  localparam int unsigned FracBits     = DataWidth - 4;
  localparam int unsigned CordicStages = 14;
  localparam int unsigned CordicGuard  = 8;
  // CORDIC datapath: operand plus guard bits plus growth headroom
  localparam int unsigned CW           = DataWidth + CordicGuard + 3;
  localparam int unsigned ZW           = FracBits + 4;
  localparam int unsigned Lat          = CordicStages + 3;

  typedef enum logic [2:0] {
    CmdAdd   = 3'd0,
    CmdSub   = 3'd1,
    CmdMul   = 3'd2,
    CmdConj  = 3'd3,
    CmdScale = 3'd4,
    CmdEq    = 3'd5,
    CmdPolar = 3'd6
  } cmd_e;

  localparam logic signed [63:0] HalfPiQ30   = 64'sd1686629713;
  localparam logic signed [63:0] InvGainQ30  = 64'sd652032874;

  function automatic logic signed [63:0] atan_q30(input int unsigned i);
    case (i)
      0: atan_q30 = 64'sd843314857;   1: atan_q30 = 64'sd497837829;
      2: atan_q30 = 64'sd263043837;   3: atan_q30 = 64'sd133525159;
      4: atan_q30 = 64'sd67021687;    5: atan_q30 = 64'sd33543516;
      6: atan_q30 = 64'sd16775851;    7: atan_q30 = 64'sd8388437;
      8: atan_q30 = 64'sd4194283;     9: atan_q30 = 64'sd2097149;
      default: atan_q30 = 64'sd1 <<< (30 - i);
    endcase
  endfunction

  // atan(2^-i) rounded half up to FracBits
  function automatic logic signed [ZW-1:0] atan_fix(input int unsigned i);
    logic signed [63:0] v;
    v = (atan_q30(i) + (64'sd1 <<< (30 - FracBits - 1))) >>> (30 - FracBits);
    atan_fix = ZW'(v);
  endfunction

  function automatic logic signed [ZW-1:0] half_pi_fix();
    logic signed [63:0] v;
    v = (HalfPiQ30 + (64'sd1 <<< (30 - FracBits - 1))) >>> (30 - FracBits);
    half_pi_fix = ZW'(v);
  endfunction

  typedef struct packed {
    logic [2:0]                  cmd;
    logic signed [DataWidth-1:0] re;
    logic signed [DataWidth-1:0] im;
    logic                        eq;
    logic                        sat;
  } side_t;

  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } crd_t;

  typedef struct packed {
    logic                        valid;
    side_t                       side;
  } ctl_t;

endpackage

@@ rtl/core/cau_if.sv @@
// ============================================================================
// cau_in_if / cau_out_if: request and result channels
// Valid/ready handshake with the work fields as payload.
// ============================================================================
interface cau_in_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 command;
  logic signed [cau_pkg::DataWidth-1:0] a_real;
  logic signed [cau_pkg::DataWidth-1:0] a_imag;
  logic signed [cau_pkg::DataWidth-1:0] b_real;
  logic signed [cau_pkg::DataWidth-1:0] b_imag;
  logic signed [cau_pkg::DataWidth-1:0] scale_factor;
  modport source (output valid, command, a_real, a_imag, b_real, b_imag,
                  scale_factor, input ready);
  modport sink   (input valid, command, a_real, a_imag, b_real, b_imag,
                  scale_factor, output ready);
  modport monitor (input valid, ready, command, a_real, a_imag, b_real, b_imag,
                   scale_factor);
endinterface

interface cau_out_if;
  logic                       valid;
  logic                       ready;
  logic signed [cau_pkg::DataWidth-1:0] result_real;
  logic signed [cau_pkg::DataWidth-1:0] result_imag;
  logic                       is_equal;
  logic                       saturated;
  modport source (output valid, result_real, result_imag, is_equal, saturated,
                  input ready);
  modport sink   (input valid, result_real, result_imag, is_equal, saturated,
                  output ready);
  modport monitor (input valid, ready, result_real, result_imag, is_equal,
                   saturated);
endinterface

@@ rtl/core/complex_arithmetic_unit_core.sv @@
// ============================================================================
// complex_arithmetic_unit_core: pipelined complex ALU
// Add, subtract, multiply, conjugate, scale, compare and CORDIC polar.
// ============================================================================
//  channel  | dir | handshake   | payload
//  in_if    | in  | valid/ready | command, a/b real/imag, scale_factor
//  out_if   | out | valid/ready | result_real/imag, is_equal, saturated
//
// One request per cycle unless the output stalls; each passes the front stages,
// the chain of CORDIC cells, one cell per rotation, and the back registers.
// The whole pipeline advances together; it holds when the output register
// is full and not taken. Reset clears only valid flags.
module complex_arithmetic_unit_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  cau_in_if.sink    in_if,
  cau_out_if.source out_if
);
  localparam int unsigned N = cau_pkg::CordicStages;

  logic en;
  cau_pkg::crd_t crd [N+1];
  cau_pkg::ctl_t ctl [N+1];
  cau_pkg::side_t side;

  assign en          = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  cau_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_if.valid), .cmd_i(in_if.command),
    .ar_i(in_if.a_real), .ai_i(in_if.a_imag), .br_i(in_if.b_real),
    .bi_i(in_if.b_imag), .sf_i(in_if.scale_factor),
    .crd_o(crd[0]), .ctl_o(ctl[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    cau_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .stage_i(5'(g)),
      .crd_i(crd[g]), .ctl_i(ctl[g]), .crd_o(crd[g+1]), .ctl_o(ctl[g+1])
    );
  end

  cau_back u_back (
    .clk_i, .rst_ni, .en_i(en), .crd_i(crd[N]), .ctl_i(ctl[N]),
    .valid_o(out_if.valid), .side_o(side)
  );

  assign out_if.result_real = side.re;
  assign out_if.result_imag = side.im;
  assign out_if.is_equal    = side.eq;
  assign out_if.saturated   = side.sat;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(side))
    else $error("result changed under stall");
  a_eq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.is_equal |-> out_if.result_real == '0 &&
    out_if.result_imag == '0 && !out_if.saturated)
    else $error("equals result not clean");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_if.valid |-> in_if.ready)
    else $error("stalled with empty output");
`endif
endmodule

@@ rtl/core/cau_cell.sv @@
// ============================================================================
// cau_cell: one CORDIC vectoring cell
// Rotates toward the x axis by atan(2^-stage) and hands the item on.
// ============================================================================
module cau_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [4:0]      stage_i,
  input  cau_pkg::crd_t   crd_i,
  input  cau_pkg::ctl_t   ctl_i,
  output cau_pkg::crd_t   crd_o,
  output cau_pkg::ctl_t   ctl_o
);
  cau_pkg::crd_t crd_d, crd_q;
  cau_pkg::ctl_t ctl_q;
  logic signed [cau_pkg::CW-1:0] dx, dy;
  logic signed [cau_pkg::ZW-1:0] a;

  always_comb begin
    dx    = crd_i.y >>> stage_i;
    dy    = crd_i.x >>> stage_i;
    a     = cau_pkg::atan_fix(32'(stage_i));
    crd_d = crd_i;
    if (!crd_i.y[cau_pkg::CW-1]) begin
      crd_d.x = crd_i.x + dx;
      crd_d.y = crd_i.y - dy;
      crd_d.z = crd_i.z + a;
    end else begin
      crd_d.x = crd_i.x - dx;
      crd_d.y = crd_i.y + dy;
      crd_d.z = crd_i.z - a;
    end
  end

  // only the valid flags are reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.valid <= 1'b0;
      crd_q.valid <= 1'b0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
      crd_q <= crd_d;
    end
  end

  assign crd_o = crd_q;
  assign ctl_o = ctl_q;
endmodule

@@ rtl/core/cau_front.sv @@
// ============================================================================
// cau_front: operand stage
// Products, sums, equality and CORDIC pre-rotation for one request.
// ============================================================================
module cau_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [2:0]                        cmd_i,
  input  logic signed [cau_pkg::DataWidth-1:0] ar_i,
  input  logic signed [cau_pkg::DataWidth-1:0] ai_i,
  input  logic signed [cau_pkg::DataWidth-1:0] br_i,
  input  logic signed [cau_pkg::DataWidth-1:0] bi_i,
  input  logic signed [cau_pkg::DataWidth-1:0] sf_i,
  output cau_pkg::crd_t                     crd_o,
  output cau_pkg::ctl_t                     ctl_o
);
  localparam int unsigned DW = cau_pkg::DataWidth;
  localparam int unsigned PW = 2 * DW;
  localparam logic signed [DW+1:0] Hi = (DW+2)'((1 << (DW - 1)) - 1);
  localparam logic signed [DW+1:0] Lo = -Hi - 1;

  // stage 1: registered products, sums, equality and pre-rotation
  logic                   v1_q;
  logic [2:0]             c1_q;
  logic signed [PW-1:0]   p0_q, p1_q, p2_q, p3_q;
  logic signed [DW:0]     s0_q, s1_q;
  logic                   eq1_q;
  cau_pkg::crd_t          crd1_q;

  logic signed [PW-1:0]   m0, m1, m2, m3;
  logic signed [DW:0]     s0, s1;
  cau_pkg::crd_t          pre;
  logic signed [cau_pkg::CW-1:0] xg, yg;

  always_comb begin
    m0 = ar_i * br_i;
    m1 = ai_i * bi_i;
    m2 = ar_i * bi_i;
    m3 = ai_i * br_i;
    s0 = '0;
    s1 = '0;
    case (cmd_i)
      cau_pkg::CmdAdd:   begin s0 = ar_i + br_i; s1 = ai_i + bi_i; end
      cau_pkg::CmdSub:   begin s0 = ar_i - br_i; s1 = ai_i - bi_i; end
      cau_pkg::CmdConj:  begin s0 = (DW+1)'(ar_i); s1 = -(DW+1)'(ai_i); end
      cau_pkg::CmdScale: begin end
      default:           begin end
    endcase
    if (cmd_i == cau_pkg::CmdScale) begin
      m0 = ar_i * sf_i;
      m2 = ai_i * sf_i;
      m1 = '0;
      m3 = '0;
    end
    xg = cau_pkg::CW'(ar_i) <<< cau_pkg::CordicGuard;
    yg = cau_pkg::CW'(ai_i) <<< cau_pkg::CordicGuard;
    pre.valid = 1'b1;
    pre.zero  = (ar_i == '0) && (ai_i == '0);
    pre.x = xg;
    pre.y = yg;
    pre.z = '0;
    if (ar_i[DW-1]) begin
      if (!ai_i[DW-1]) begin
        pre.x = yg; pre.y = -xg; pre.z = cau_pkg::half_pi_fix();
      end else begin
        pre.x = -yg; pre.y = xg; pre.z = -cau_pkg::half_pi_fix();
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en_i) v1_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q <= cmd_i; p0_q <= m0; p1_q <= m1; p2_q <= m2; p3_q <= m3;
      s0_q <= s0; s1_q <= s1;
      eq1_q <= (ar_i == br_i) && (ai_i == bi_i);
      crd1_q <= pre;
    end
  end

  // stage 2: combine, round, saturate
  logic signed [PW+1:0] r0, r1;
  logic signed [DW+1:0] w0, w1;
  cau_pkg::side_t       sd;

  function automatic logic signed [DW+1:0] rnd(input logic signed [PW+1:0] v);
    logic signed [PW+1:0] t;
    t = (v + (PW+2)'(1 << (cau_pkg::FracBits - 1))) >>> cau_pkg::FracBits;
    if (t > (PW+2)'(Hi))      rnd = Hi + 1;
    else if (t < (PW+2)'(Lo)) rnd = Lo - 1;
    else                      rnd = (DW+2)'(t);
  endfunction

  always_comb begin
    r0 = (PW+2)'(p0_q) - (PW+2)'(p1_q);
    r1 = (PW+2)'(p2_q) + (PW+2)'(p3_q);
    w0 = '0;
    w1 = '0;
    sd.cmd = c1_q;
    sd.eq  = 1'b0;
    case (c1_q)
      cau_pkg::CmdAdd, cau_pkg::CmdSub, cau_pkg::CmdConj: begin
        w0 = (DW+2)'(s0_q); w1 = (DW+2)'(s1_q);
      end
      cau_pkg::CmdMul, cau_pkg::CmdScale: begin
        w0 = rnd(r0); w1 = rnd(r1);
      end
      cau_pkg::CmdEq: sd.eq = eq1_q;
      default: begin end
    endcase
    sd.sat = (w0 > Hi) || (w0 < Lo) || (w1 > Hi) || (w1 < Lo);
    sd.re  = (w0 > Hi) ? DW'(Hi) : (w0 < Lo) ? DW'(Lo) : DW'(w0);
    sd.im  = (w1 > Hi) ? DW'(Hi) : (w1 < Lo) ? DW'(Lo) : DW'(w1);
  end

  // only the valid flags are reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o.valid <= 1'b0;
      crd_o.valid <= 1'b0;
    end else if (en_i) begin
      ctl_o.valid <= v1_q;
      crd_o.valid <= v1_q;
      ctl_o.side  <= sd;
      crd_o.zero  <= crd1_q.zero;
      crd_o.x     <= crd1_q.x;
      crd_o.y     <= crd1_q.y;
      crd_o.z     <= crd1_q.z;
    end
  end
endmodule

@@ rtl/core/cau_back.sv @@
// ============================================================================
// cau_back: polar finish and output register
// Gain correction of the CORDIC magnitude, result select and saturation.
// ============================================================================
module cau_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  cau_pkg::crd_t          crd_i,
  input  cau_pkg::ctl_t          ctl_i,
  output logic                   valid_o,
  output cau_pkg::side_t         side_o
);
  localparam int unsigned DW = cau_pkg::DataWidth;
  localparam int unsigned MW = cau_pkg::CW - cau_pkg::CordicGuard + 1;
  localparam logic signed [63:0] Hi = 64'sd1 <<< (DW - 1);

  logic signed [MW-1:0]  m;
  logic signed [MW+31:0] prod_q;
  cau_pkg::crd_t         crd_q;
  cau_pkg::ctl_t         ctl_q;

  assign m = MW'((crd_i.x + cau_pkg::CW'(1 << (cau_pkg::CordicGuard - 1)))
                 >>> cau_pkg::CordicGuard);

  logic signed [MW+31:0] mag;
  logic signed [63:0]    mg, ph;
  cau_pkg::side_t        sd;

  always_comb begin
    mag = (prod_q + (MW+32)'(64'sd1 <<< 29)) >>> 30;
    mg  = crd_q.zero ? 64'sd0 : 64'(mag);
    ph  = crd_q.zero ? 64'sd0 : 64'(crd_q.z);
    sd  = ctl_q.side;
    if (ctl_q.side.cmd == cau_pkg::CmdPolar) begin
      sd.sat = (mg > Hi - 1) || (mg < -Hi) || (ph > Hi - 1) || (ph < -Hi);
      sd.re  = (mg > Hi - 1) ? DW'(Hi - 1) : (mg < -Hi) ? DW'(-Hi) : DW'(mg);
      sd.im  = (ph > Hi - 1) ? DW'(Hi - 1) : (ph < -Hi) ? DW'(-Hi) : DW'(ph);
    end
  end

  // only the valid flags are reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.valid <= 1'b0;
      valid_o     <= 1'b0;
    end else if (en_i) begin
      ctl_q   <= ctl_i;
      valid_o <= ctl_q.valid;
      prod_q  <= (MW+32)'(m) * (MW+32)'(cau_pkg::InvGainQ30);
      crd_q   <= crd_i;
      side_o  <= sd;
    end
  end
endmodule

@@ tb/cau_checker.sv @@
// ----------------------------------------------------------------------------
// cau_checker: result predictor and scoreboard for the complex ALU
// Watches request and result channels, computes each expected result from the
// request fields and compares every result field against the oldest one.
// ----------------------------------------------------------------------------
module cau_checker (
  input  logic clk_i,
  input  logic rst_ni,
  cau_in_if.monitor  req_mon,
  cau_out_if.monitor res_mon,
  output int      fail_cnt_o,
  output int      pending_o,
  output logic    accepted_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [cau_pkg::DataWidth-1:0] re;
    logic signed [cau_pkg::DataWidth-1:0] im;
    logic eq;
    logic sat;
  } alu_res_t;

  alu_res_t expected_q[$];
  int fail_cnt;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = expected_q.size();
  assign accepted_o = (req_mon.valid && req_mon.ready) ||
                      (res_mon.valid && res_mon.ready);

  function automatic longint fl_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shr(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sum_prod(longint p, longint q);
    if (p > 0 && q > 64'sh7fffffffffffffff - p) return longint'(1) <<< 62;
    return p + q;
  endfunction

  function automatic logic signed [cau_pkg::DataWidth-1:0] clamp(longint v,
                                                                 inout logic sat);
    longint hi, lo;
    hi = (longint'(1) <<< (cau_pkg::DataWidth - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin v = hi; sat = 1'b1; end
    if (v < lo) begin v = lo; sat = 1'b1; end
    return v[cau_pkg::DataWidth-1:0];
  endfunction

  // fixed-point table values, written out (Q30 atan(2^-i))
  function automatic longint atan_tab(int i);
    longint t[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                      33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return t[i];
    return longint'(1) <<< (30 - i);
  endfunction

  function automatic void cordic_polar(longint x0, longint y0, output longint mag,
                                       output longint ph);
    longint x, y, z, t, dx, dy, a, m;
    z = 0;
    mag = 0;
    ph = 0;
    if (x0 == 0 && y0 == 0) return;
    x = x0 * 256;
    y = y0 * 256;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = rnd_shr(1686629713, 30 - cau_pkg::FracBits);
      end else begin
        x = -y; y = t; z = -rnd_shr(1686629713, 30 - cau_pkg::FracBits);
      end
    end
    for (int i = 0; i < cau_pkg::CordicStages && i < 30; i++) begin
      dx = fl_shr(y, i);
      dy = fl_shr(x, i);
      a  = rnd_shr(atan_tab(i), 30 - cau_pkg::FracBits);
      if (y >= 0) begin x += dx; y -= dy; z += a; end
      else begin x -= dx; y += dy; z -= a; end
    end
    m   = rnd_shr(x, 8);
    mag = rnd_shr(m * 652032874, 30);
    ph  = z;
  endfunction

  function automatic alu_res_t predict_alu(logic [2:0] cmd, longint ar, longint ai,
                                           longint br, longint bi, longint s);
    alu_res_t r;
    longint re, im;
    logic sat;
    re = 0; im = 0; sat = 1'b0; r.eq = 1'b0;
    case (cmd)
      cau_pkg::CmdAdd:   begin re = ar + br; im = ai + bi; end
      cau_pkg::CmdSub:   begin re = ar - br; im = ai - bi; end
      cau_pkg::CmdMul: begin
        re = rnd_shr(sum_prod(ar * br, -(ai * bi)), cau_pkg::FracBits);
        im = rnd_shr(sum_prod(ar * bi, ai * br), cau_pkg::FracBits);
      end
      cau_pkg::CmdConj:  begin re = ar; im = -ai; end
      cau_pkg::CmdScale: begin
        re = rnd_shr(ar * s, cau_pkg::FracBits);
        im = rnd_shr(ai * s, cau_pkg::FracBits);
      end
      cau_pkg::CmdEq:    r.eq = (ar == br && ai == bi);
      cau_pkg::CmdPolar: cordic_polar(ar, ai, re, im);
      default: ;
    endcase
    r.re  = clamp(re, sat);
    r.im  = clamp(im, sat);
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_cnt++;
  endtask

  initial fail_cnt = 0;

  always @(posedge clk_i) begin
    alu_res_t e;
    if (rst_ni) begin
      if (req_mon.valid && req_mon.ready)
        expected_q.push_back(predict_alu(req_mon.command, req_mon.a_real,
                                         req_mon.a_imag, req_mon.b_real,
                                         req_mon.b_imag, req_mon.scale_factor));
      if (res_mon.valid && res_mon.ready) begin
        if (expected_q.size() == 0) report_mismatch("unexpected result", 0, 0);
        else begin
          e = expected_q.pop_front();
          if (res_mon.result_real !== e.re)
            report_mismatch("result_real", res_mon.result_real, e.re);
          if (res_mon.result_imag !== e.im)
            report_mismatch("result_imag", res_mon.result_imag, e.im);
          if (res_mon.is_equal !== e.eq)
            report_mismatch("is_equal", res_mon.is_equal, e.eq);
          if (res_mon.saturated !== e.sat)
            report_mismatch("saturated", res_mon.saturated, e.sat);
        end
      end
    end
  end
endmodule

@@ tb/tb_complex_arithmetic_unit_core.sv @@
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit_core: stimulus and verdict for the complex ALU
// Directed corner requests then random ones under three idling profiles;
// the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt, pending, idle_cycles, req_cnt;
  int   src_idle_pct, snk_idle_pct;
  logic accepted;

  cau_in_if  req_ch ();
  cau_out_if res_ch ();

  complex_arithmetic_unit_core dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_if(req_ch),
                                    .out_if(res_ch));
  cau_checker chk (.clk_i(clk_i), .rst_ni(rst_ni), .req_mon(req_ch), .res_mon(res_ch),
                   .fail_cnt_o(fail_cnt), .pending_o(pending), .accepted_o(accepted));

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.command = cau_pkg::CmdAdd;
    req_ch.a_real = '0; req_ch.a_imag = '0; req_ch.b_real = '0; req_ch.b_imag = '0;
    req_ch.scale_factor = '0;
    res_ch.ready = 1'b0;
  end

  // receiver stalls
  always @(negedge clk_i)
    res_ch.ready <= rst_ni && ($urandom_range(99) >= snk_idle_pct);

  always @(posedge clk_i) begin
    if (!rst_ni || accepted) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Watchdog: no traffic for %0d cycles", IdleLimit);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [15:0] pick_val();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(8192)) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  // valid stays high into the next request; it drops while idling and in drain
  task automatic send_req(logic [2:0] cmd, logic [15:0] ar, logic [15:0] ai,
                          logic [15:0] br, logic [15:0] bi, logic [15:0] sf);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.command <= cmd;
    req_ch.a_real <= ar; req_ch.a_imag <= ai;
    req_ch.b_real <= br; req_ch.b_imag <= bi;
    req_ch.scale_factor <= sf;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    req_cnt++;
    @(negedge clk_i);
  endtask

  task automatic send_random(int n);
    logic [15:0] ar, ai;
    for (int i = 0; i < n; i++) begin
      ar = pick_val(); ai = pick_val();
      // half the requests are equals with matching operands
      if ($urandom_range(1)) send_req(3'($urandom_range(7)), ar, ai, pick_val(),
                                      pick_val(), pick_val());
      else send_req(cau_pkg::CmdEq, ar, ai, ar, ai, pick_val());
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (cau_pkg::Lat + 8) @(negedge clk_i);
  endtask

  initial begin
    req_cnt = 0;
    src_idle_pct = 38; snk_idle_pct = 88;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // corner cases
    send_req(cau_pkg::CmdAdd, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, '0);
    send_req(cau_pkg::CmdSub, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, '0);
    send_req(cau_pkg::CmdMul, 16'h8000, 16'h8000, 16'h8000, 16'h8000, '0);
    send_req(cau_pkg::CmdMul, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, '0);
    send_req(cau_pkg::CmdMul, 16'h1000, 16'h0800, 16'h2000, 16'hf000, '0);
    send_req(cau_pkg::CmdConj, 16'h1234, 16'h8000, '0, '0, '0);
    send_req(cau_pkg::CmdConj, 16'h8000, 16'h7fff, '0, '0, '0);
    send_req(cau_pkg::CmdScale, 16'h7fff, 16'h8000, '0, '0, 16'h8000);
    send_req(cau_pkg::CmdScale, 16'h1000, 16'hf000, '0, '0, 16'h0001);
    send_req(cau_pkg::CmdEq, 16'h1234, 16'h5678, 16'h1234, 16'h5678, '0);
    send_req(cau_pkg::CmdEq, 16'h1234, 16'h5678, 16'h1234, 16'h5679, '0);
    send_req(cau_pkg::CmdPolar, '0, '0, '0, '0, '0);
    send_req(cau_pkg::CmdPolar, 16'hf000, '0, '0, '0, '0);
    send_req(cau_pkg::CmdPolar, 16'h8000, 16'h8000, '0, '0, '0);
    send_req(cau_pkg::CmdPolar, 16'h7fff, 16'h7fff, '0, '0, '0);
    send_req(cau_pkg::CmdPolar, 16'h8000, 16'h7fff, '0, '0, '0);
    send_req(cau_pkg::CmdPolar, '0, 16'h8000, '0, '0, '0);
    send_req(3'd7, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_random(150);
    drain(); // pause until all results are back
    src_idle_pct = 88; snk_idle_pct = 38;
    send_random(200);
    src_idle_pct = 0; snk_idle_pct = 0;
    send_random(200);
    drain();
    $display("Sent %0d requests covering all commands, saturation and CORDIC corners",
             req_cnt);
    $display("Idling profiles: slow sink, slow source, then back-to-back");
    if (fail_cnt == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
